@@ hw/rtl/xfpr_pkg.sv @@
// Shared types and constants for the framed packet receiver.
// No dependencies; imported by every module of the block but xfpr_ram.
`default_nettype none
package xfpr_pkg;

  localparam int BYTE_W = 8;
  localparam int ID_W   = 5;
  localparam int LEN_W  = 6;
  localparam int EN_W   = 16;

  localparam logic [BYTE_W-1:0] SYNC_A    = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_B    = 8'h55;
  localparam logic [BYTE_W-1:0] TAIL_MARK = 8'hEE;

  typedef enum logic [6:0] {
    ST_HUNT  = 7'b0000001,
    ST_SYNC2 = 7'b0000010,
    ST_ID    = 7'b0000100,
    ST_LEN   = 7'b0001000,
    ST_DATA  = 7'b0010000,
    ST_CHECK = 7'b0100000,
    ST_TAIL  = 7'b1000000
  } parse_state_t;

  // frame descriptor handed from parser to drain
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [LEN_W-1:0] length;
    logic             bank;
  } frame_desc_t;

  // drain tells parser a buffer bank is free again
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_release_t;

endpackage
`default_nettype wire

@@ hw/rtl/xfpr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module xfpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/xfpr_parser.sv @@
// Front end: frame parser, payload writes into the current buffer bank,
// enable register and bank ownership. Depends on xfpr_pkg.
`default_nettype none
module xfpr_parser import xfpr_pkg::*; #(
  parameter int MAX_ID      = 16,
  parameter int MAX_PAYLOAD = 59,
  parameter int IDX_W       = $clog2(MAX_PAYLOAD + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [BYTE_W-1:0]   in_rx_byte,
  input  wire logic                cfg_wr_en,
  input  wire logic [EN_W-1:0]     cfg_wr_data,
  output logic                     wr_en,
  output logic [IDX_W:0]           wr_addr,
  output logic [BYTE_W-1:0]        wr_data,
  output logic                     push,
  output frame_desc_t              push_desc,
  input  wire bank_release_t       release_i
);

  localparam logic [BYTE_W-1:0] MAX_ID_B  = BYTE_W'(MAX_ID);
  localparam logic [BYTE_W-1:0] MAX_PAY_B = BYTE_W'(MAX_PAYLOAD);

  parse_state_t      state_r, state_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] xor_r, xor_nxt;
  logic              wbank_r, wbank_nxt;
  logic [1:0]        busy_r, busy_nxt;
  logic [EN_W-1:0]   en_ids_r;

  logic              accept;
  logic [LEN_W:0]    cnt_inc;
  logic [ID_W-1:0]   id_m1;
  logic              id_en;

  assign in_stall  = busy_r[wbank_r];
  assign accept    = in_valid && !in_stall;
  assign cnt_inc   = {1'b0, cnt_r} + (LEN_W+1)'(1);
  assign id_m1     = id_r - ID_W'(1);
  assign id_en     = (id_m1 < ID_W'(EN_W)) && en_ids_r[id_m1[3:0]];

  assign wr_addr   = {wbank_r, cnt_r[IDX_W-1:0]};
  assign wr_data   = in_rx_byte;
  assign push_desc = '{id: id_r, length: len_r, bank: wbank_r};

  always_comb begin
    state_nxt = state_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    xor_nxt   = xor_r;
    wbank_nxt = wbank_r;
    wr_en     = 1'b0;
    push      = 1'b0;
    if (accept) begin
      case (state_r)
        ST_HUNT: begin
          if (in_rx_byte == SYNC_A) state_nxt = ST_SYNC2;
        end
        ST_SYNC2: begin
          state_nxt = (in_rx_byte == SYNC_B) ? ST_ID : ST_HUNT;
        end
        ST_ID: begin
          if (in_rx_byte == '0 || in_rx_byte > MAX_ID_B) begin
            state_nxt = ST_HUNT;
          end else begin
            id_nxt    = in_rx_byte[ID_W-1:0];
            state_nxt = ST_LEN;
          end
        end
        ST_LEN: begin
          if (in_rx_byte > MAX_PAY_B) begin
            state_nxt = ST_HUNT;
          end else begin
            len_nxt   = in_rx_byte[LEN_W-1:0];
            cnt_nxt   = '0;
            xor_nxt   = '0;
            state_nxt = (in_rx_byte == '0) ? ST_CHECK : ST_DATA;
          end
        end
        ST_DATA: begin
          wr_en   = 1'b1;
          xor_nxt = xor_r ^ in_rx_byte;
          cnt_nxt = cnt_inc[LEN_W-1:0];
          if (cnt_inc >= {1'b0, len_r}) state_nxt = ST_CHECK;
        end
        ST_CHECK: begin
          state_nxt = (in_rx_byte == xor_r) ? ST_TAIL : ST_HUNT;
        end
        ST_TAIL: begin
          if (in_rx_byte == TAIL_MARK && id_en) begin
            push      = 1'b1;
            wbank_nxt = ~wbank_r;
          end
          state_nxt = ST_HUNT;
        end
        default: begin
          state_nxt = ST_HUNT;
        end
      endcase
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (release_i.valid) busy_nxt[release_i.bank] = 1'b0;
    if (push) busy_nxt[wbank_r] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_HUNT;
      id_r     <= '0;
      len_r    <= '0;
      cnt_r    <= '0;
      xor_r    <= '0;
      wbank_r  <= 1'b0;
      busy_r   <= '0;
      en_ids_r <= '0;
    end else begin
      state_r <= state_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      xor_r   <= xor_nxt;
      wbank_r <= wbank_nxt;
      busy_r  <= busy_nxt;
      if (cfg_wr_en) en_ids_r <= cfg_wr_data;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/xfpr_desc_fifo.sv @@
// Two-entry queue of frame descriptors between parser and drain.
// Depends on xfpr_pkg.
`default_nettype none
module xfpr_desc_fifo import xfpr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire frame_desc_t push_desc,
  input  wire logic        pop,
  output logic             not_empty,
  output frame_desc_t      head
);

  frame_desc_t e0_r, e0_nxt, e1_r, e1_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [1:0]  cnt_after_pop;

  assign not_empty     = (cnt_r != 2'd0);
  assign head          = e0_r;
  assign cnt_after_pop = (pop && not_empty) ? cnt_r - 2'd1 : cnt_r;

  always_comb begin
    e0_nxt  = e0_r;
    e1_nxt  = e1_r;
    if (pop && not_empty) e0_nxt = e1_r;
    if (push) begin
      if (cnt_after_pop == 2'd0) e0_nxt = push_desc;
      else                       e1_nxt = push_desc;
    end
    cnt_nxt = cnt_after_pop + {1'b0, push};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

endmodule
`default_nettype wire

@@ hw/rtl/xfpr_drain.sv @@
// Back end: walks a frame's buffered payload and drives the result channel
// through a read stage and an output register. Depends on xfpr_pkg.
`default_nettype none
module xfpr_drain import xfpr_pkg::*; #(
  parameter int MAX_PAYLOAD = 59,
  parameter int IDX_W       = $clog2(MAX_PAYLOAD + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_not_empty,
  input  wire frame_desc_t       q_head,
  output logic                   q_pop,
  output logic                   rd_en,
  output logic [IDX_W:0]         rd_addr,
  input  wire logic [BYTE_W-1:0] rd_data,
  output bank_release_t          release_o,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [ID_W-1:0]        out_frame_id,
  output logic [LEN_W-1:0]       out_frame_length,
  output logic [BYTE_W-1:0]      out_payload_byte,
  output logic [LEN_W-1:0]       out_byte_index,
  output logic                   out_last
);

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [LEN_W-1:0] length;
    logic [LEN_W-1:0] index;
    logic             last;
    logic             empty;
  } rd_meta_t;

  logic              active_r;
  frame_desc_t       cur_r;
  logic [LEN_W-1:0]  k_r;
  logic              s1_valid_r;
  rd_meta_t          s1_r;
  logic              out_valid_r;
  rd_meta_t          out_meta_r;
  logic [BYTE_W-1:0] out_byte_r;

  logic              adv_out, s1_move, s1_free;
  logic [LEN_W:0]    k_inc;
  logic              is_last;
  rd_meta_t          issue_meta;

  assign adv_out = !out_valid_r || !out_stall;
  assign s1_move = s1_valid_r && adv_out;
  assign s1_free = !s1_valid_r || s1_move;
  assign rd_en   = active_r && s1_free;
  assign q_pop   = !active_r && q_not_empty;
  assign rd_addr = {cur_r.bank, k_r[IDX_W-1:0]};
  assign k_inc   = {1'b0, k_r} + (LEN_W+1)'(1);
  assign is_last = (cur_r.length == '0) || (k_inc == {1'b0, cur_r.length});

  assign issue_meta = '{id: cur_r.id, length: cur_r.length, index: k_r,
                        last: is_last, empty: (cur_r.length == '0)};

  assign release_o = '{valid: rd_en && is_last, bank: cur_r.bank};

  assign out_valid        = out_valid_r;
  assign out_frame_id     = out_meta_r.id;
  assign out_frame_length = out_meta_r.length;
  assign out_byte_index   = out_meta_r.index;
  assign out_last         = out_meta_r.last;
  assign out_payload_byte = out_byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        active_r <= 1'b1;
      end else if (rd_en && is_last) begin
        active_r <= 1'b0;
      end
      if (rd_en) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (adv_out) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
      k_r   <= '0;
    end else if (rd_en) begin
      k_r <= k_inc[LEN_W-1:0];
    end
    if (rd_en) s1_r <= issue_meta;
    if (s1_move) begin
      out_meta_r <= s1_r;
      out_byte_r <= s1_r.empty ? '0 : rd_data;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/xor_framed_packet_receiver.sv @@
// Framed packet receiver: takes link bytes, checks 0xAA 0x55 id len
// payload xor 0xEE frames and emits the payload of good, enabled frames.
// Inputs accept one byte per beat on in_valid/in_stall; results leave one
// payload byte per beat on out_valid/out_stall, last byte flagged by
// out_last. An enabled empty frame yields a single beat with out_last set.
// cfg_wr_en/cfg_wr_data write the enabled-id mask (bit n = id n+1).
// Payload is buffered in a two-bank RAM: the parser fills one bank while
// the drain side empties the other. A queued frame's bytes are read from
// the RAM and registered at the output, one beat per cycle while out_stall
// is low; the next descriptor is popped before the next frame's first read.
// Input runs at one byte per cycle while in_stall is low; in_stall rises
// only while the bank the parser writes into still holds a frame the drain
// has not finished reading, i.e. two good, enabled frames wait on a stall.
// Reset (rst_n low, synchronous) returns the parser to hunting, clears the
// mask, empties the queue and drops any pending results.
// Depends on xfpr_pkg, xfpr_parser, xfpr_desc_fifo, xfpr_drain, xfpr_ram.
`default_nettype none
module xor_framed_packet_receiver import xfpr_pkg::*; #(
  parameter int MAX_ID      = 16,
  parameter int MAX_PAYLOAD = 59
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [BYTE_W-1:0] in_rx_byte,
  input  wire logic              cfg_wr_en,
  input  wire logic [EN_W-1:0]   cfg_wr_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [ID_W-1:0]        out_frame_id,
  output logic [LEN_W-1:0]       out_frame_length,
  output logic [BYTE_W-1:0]      out_payload_byte,
  output logic [LEN_W-1:0]       out_byte_index,
  output logic                   out_last
);

  localparam int IDX_W     = $clog2(MAX_PAYLOAD + 1);
  localparam int RAM_DEPTH = 2 << IDX_W;

  logic              wr_en, rd_en;
  logic [IDX_W:0]    wr_addr, rd_addr;
  logic [BYTE_W-1:0] wr_data, rd_data;
  logic              push, pop, q_not_empty;
  frame_desc_t       push_desc, q_head;
  bank_release_t     bank_rel;

  xfpr_parser #(
    .MAX_ID      (MAX_ID),
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .IDX_W       (IDX_W)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_rx_byte  (in_rx_byte),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .push        (push),
    .push_desc   (push_desc),
    .release_i   (bank_rel)
  );

  xfpr_desc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  xfpr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  xfpr_drain #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .IDX_W       (IDX_W)
  ) u_drain (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_head           (q_head),
    .q_pop            (pop),
    .rd_en            (rd_en),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .release_o        (bank_rel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_id     (out_frame_id),
    .out_frame_length (out_frame_length),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_last         (out_last)
  );

endmodule
`default_nettype wire

@@ tb/xfpr_checker.sv @@
// Scoreboard for the framed packet receiver: watches link and payload beats,
// tracks the frame parser and the id mask, and compares every payload beat.
// Depends on xfpr_pkg.
module xfpr_checker import xfpr_pkg::*; #(
  parameter int MAX_ID      = 16,
  parameter int MAX_PAYLOAD = 59
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire logic [BYTE_W-1:0] in_rx_byte,
  input  wire logic              cfg_wr_en,
  input  wire logic [EN_W-1:0]   cfg_wr_data,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire logic [ID_W-1:0]   out_frame_id,
  input  wire logic [LEN_W-1:0]  out_frame_length,
  input  wire logic [BYTE_W-1:0] out_payload_byte,
  input  wire logic [LEN_W-1:0]  out_byte_index,
  input  wire logic              out_last,
  output int                     mismatch_count,
  output int                     beats_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ID_W-1:0]   frame_id;
    logic [LEN_W-1:0]  frame_length;
    logic [BYTE_W-1:0] payload_byte;
    logic [LEN_W-1:0]  byte_index;
    logic              last;
  } payload_beat_t;

  payload_beat_t     expected_beats[$];
  parse_state_t      rx_state;
  logic [ID_W-1:0]   cur_id;
  logic [LEN_W-1:0]  cur_len;
  logic [LEN_W-1:0]  rx_count;
  logic [BYTE_W-1:0] rx_xor;
  logic [EN_W-1:0]   id_mask;
  logic [BYTE_W-1:0] frame_bytes [MAX_PAYLOAD];

  initial begin
    mismatch_count = 0;
    beats_pending  = 0;
  end

  task automatic report_beat(input string what, input payload_beat_t want,
                             input payload_beat_t got);
    if (mismatch_count < 10) begin
      $display("%0t: %s: exp id=%0d len=%0d byte=%02h idx=%0d last=%0b", $time, what,
               want.frame_id, want.frame_length, want.payload_byte, want.byte_index,
               want.last);
      $display("%0t: %s: got id=%0d len=%0d byte=%02h idx=%0d last=%0b", $time, what,
               got.frame_id, got.frame_length, got.payload_byte, got.byte_index,
               got.last);
    end
    mismatch_count++;
  endtask

  task automatic parse_link_byte(input logic [BYTE_W-1:0] b);
    payload_beat_t nb;
    case (rx_state)
      ST_HUNT: begin
        if (b == SYNC_A) rx_state = ST_SYNC2;
      end
      ST_SYNC2: begin
        rx_state = (b == SYNC_B) ? ST_ID : ST_HUNT;
      end
      ST_ID: begin
        if (b == 0 || b > MAX_ID) begin
          rx_state = ST_HUNT;
        end else begin
          cur_id   = b[ID_W-1:0];
          rx_state = ST_LEN;
        end
      end
      ST_LEN: begin
        if (b > MAX_PAYLOAD) begin
          rx_state = ST_HUNT;
        end else begin
          cur_len  = b[LEN_W-1:0];
          rx_count = '0;
          rx_xor   = '0;
          rx_state = (b == 0) ? ST_CHECK : ST_DATA;
        end
      end
      ST_DATA: begin
        frame_bytes[rx_count] = b;
        rx_xor   = rx_xor ^ b;
        rx_count = rx_count + 1'b1;
        if (rx_count >= cur_len) rx_state = ST_CHECK;
      end
      ST_CHECK: begin
        rx_state = (b == rx_xor) ? ST_TAIL : ST_HUNT;
      end
      ST_TAIL: begin
        if (b == TAIL_MARK && cur_id <= ID_W'(EN_W) && id_mask[4'(cur_id - 5'd1)]) begin
          if (cur_len == 0) begin
            nb = '0;
            nb.frame_id = cur_id;
            nb.last     = 1'b1;
            expected_beats.push_back(nb);
          end else begin
            for (int k = 0; k < cur_len; k++) begin
              nb.frame_id     = cur_id;
              nb.frame_length = cur_len;
              nb.payload_byte = frame_bytes[k];
              nb.byte_index   = k[LEN_W-1:0];
              nb.last         = (k == cur_len - 1);
              expected_beats.push_back(nb);
            end
          end
        end
        rx_state = ST_HUNT;
      end
      default: begin
        rx_state = ST_HUNT;
      end
    endcase
  endtask

  always @(posedge clk) begin
    payload_beat_t got;
    payload_beat_t want;
    if (!rst_n) begin
      rx_state = ST_HUNT;
      cur_id   = '0;
      cur_len  = '0;
      rx_count = '0;
      rx_xor   = '0;
      id_mask  = '0;
      expected_beats.delete();
    end else begin
      if (cfg_wr_en) id_mask = cfg_wr_data;
      if (in_valid && !in_stall) parse_link_byte(in_rx_byte);
      if (out_valid && !out_stall) begin
        got.frame_id     = out_frame_id;
        got.frame_length = out_frame_length;
        got.payload_byte = out_payload_byte;
        got.byte_index   = out_byte_index;
        got.last         = out_last;
        if (expected_beats.size() == 0) begin
          report_beat("unexpected payload beat", '0, got);
        end else begin
          want = expected_beats.pop_front();
          if (got.frame_id !== want.frame_id || got.frame_length !== want.frame_length ||
              got.payload_byte !== want.payload_byte ||
              got.byte_index !== want.byte_index || got.last !== want.last) begin
            report_beat("payload beat mismatch", want, got);
          end
        end
      end
    end
    beats_pending <= expected_beats.size();
  end

endmodule

@@ tb/tb.sv @@
// Testbench top for the framed packet receiver: drives link bytes and the
// id mask, stalls the payload side, and gives the verdict.
// Depends on xfpr_pkg, xor_framed_packet_receiver and xfpr_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import xfpr_pkg::*;

  localparam int FRAME_MAX_ID  = 16;
  localparam int FRAME_MAX_LEN = 59;
  localparam int DRAIN_CYCLES  = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 80;

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_SYNC2,
    FRAME_BAD_ID,
    FRAME_BAD_LEN,
    FRAME_BAD_XOR,
    FRAME_BAD_TAIL,
    FRAME_TRUNCATED
  } frame_fault_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [BYTE_W-1:0] in_rx_byte;
  logic              cfg_wr_en;
  logic [EN_W-1:0]   cfg_wr_data;
  logic              out_valid;
  logic              out_stall;
  logic [ID_W-1:0]   out_frame_id;
  logic [LEN_W-1:0]  out_frame_length;
  logic [BYTE_W-1:0] out_payload_byte;
  logic [LEN_W-1:0]  out_byte_index;
  logic              out_last;
  int                mismatch_count;
  int                beats_pending;

  bit          hold_request = 1'b0;
  bit          gaps_off     = 1'b0;
  int unsigned burst_left   = 0;
  int unsigned frame_items  = 0;

  always #5 clk = ~clk;

  xor_framed_packet_receiver #(
    .MAX_ID(FRAME_MAX_ID),
    .MAX_PAYLOAD(FRAME_MAX_LEN)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_rx_byte(in_rx_byte),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_frame_id(out_frame_id),
    .out_frame_length(out_frame_length),
    .out_payload_byte(out_payload_byte),
    .out_byte_index(out_byte_index),
    .out_last(out_last)
  );

  xfpr_checker #(
    .MAX_ID(FRAME_MAX_ID),
    .MAX_PAYLOAD(FRAME_MAX_LEN)
  ) frame_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_rx_byte(in_rx_byte),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_frame_id(out_frame_id),
    .out_frame_length(out_frame_length),
    .out_payload_byte(out_payload_byte),
    .out_byte_index(out_byte_index),
    .out_last(out_last),
    .mismatch_count(mismatch_count),
    .beats_pending(beats_pending)
  );

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_link_byte(input logic [BYTE_W-1:0] b, input bit counted);
    int unsigned gap;
    if (!gaps_off && burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    if (burst_left != 0) burst_left--;
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (counted) frame_items++;
  endtask

  task automatic send_frame(input frame_fault_t fault, input logic [7:0] id,
                            input logic [7:0] len);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] b;
    int unsigned       cut;
    sum = '0;
    send_link_byte(SYNC_A, 1'b1);
    if (fault == FRAME_BAD_SYNC2) begin
      b = 8'($urandom);
      if (b == SYNC_B || $urandom_range(0, 1) == 0) b = SYNC_A;
      send_link_byte(b, 1'b1);
      return;
    end
    send_link_byte(SYNC_B, 1'b1);
    send_link_byte(id, 1'b1);
    if (fault == FRAME_BAD_ID) return;
    send_link_byte(len, 1'b1);
    if (fault == FRAME_BAD_LEN) return;
    cut = (len == 0) ? 0 : $urandom_range(0, len - 1);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      sum = sum ^ b;
      send_link_byte(b, 1'b1);
      if (fault == FRAME_TRUNCATED && i == cut) return;
    end
    if (fault == FRAME_BAD_XOR) begin
      send_link_byte(sum ^ 8'($urandom_range(1, 255)), 1'b1);
      return;
    end
    send_link_byte(sum, 1'b1);
    b = TAIL_MARK;
    if (fault == FRAME_BAD_TAIL) begin
      b = 8'($urandom);
      if (b == TAIL_MARK) b = ~TAIL_MARK;
    end
    send_link_byte(b, 1'b1);
  endtask

  task automatic send_random_frame();
    int unsigned  roll;
    frame_fault_t fault;
    logic [7:0]   id;
    logic [7:0]   len;
    roll = $urandom_range(0, 99);
    if (roll < 65)      fault = FRAME_GOOD;
    else if (roll < 70) fault = FRAME_BAD_SYNC2;
    else if (roll < 75) fault = FRAME_BAD_ID;
    else if (roll < 80) fault = FRAME_BAD_LEN;
    else if (roll < 87) fault = FRAME_BAD_XOR;
    else if (roll < 94) fault = FRAME_BAD_TAIL;
    else                fault = FRAME_TRUNCATED;
    id = 8'($urandom_range(1, FRAME_MAX_ID));
    if (fault == FRAME_BAD_ID)
      id = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(FRAME_MAX_ID + 1, 255));
    roll = $urandom_range(0, 99);
    if (roll == 0)      len = 8'(FRAME_MAX_LEN);
    else if (roll < 6)  len = 8'($urandom_range(40, FRAME_MAX_LEN));
    else if (roll < 15) len = 8'd0;
    else                len = 8'($urandom_range(1, 12));
    if (fault == FRAME_BAD_LEN) len = 8'($urandom_range(FRAME_MAX_LEN + 1, 255));
    if (fault == FRAME_TRUNCATED && len == 0) len = 8'd2;
    send_frame(fault, id, len);
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 4)) send_link_byte(8'($urandom), 1'b0);
    end
  endtask

  // mask writes only with the link idle and the payload side drained
  task automatic set_id_mask(input logic [EN_W-1:0] mask);
    in_valid <= 1'b0;
    wait (beats_pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mask;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int unsigned mode;
    int unsigned run;
    int unsigned tick;
    tick = 0;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      run  = $urandom_range(10, 80);
      repeat (run) begin
        @(negedge clk);
        if (hold_request) begin
          hold_request = 1'b0;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(negedge clk);
        end else begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= ((tick % 5) < 2);
          endcase
          tick++;
        end
      end
    end
  end

  initial begin
    logic [EN_W-1:0] phase_mask [4];
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_rx_byte  = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    phase_mask[0] = 16'hFFFF;
    phase_mask[1] = 16'h0000;
    phase_mask[2] = 16'($urandom);
    phase_mask[3] = 16'($urandom);
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: ids 1 and 16 enabled
    set_id_mask(16'h8001);
    send_frame(FRAME_GOOD, 8'd1, 8'd0);
    send_link_byte(SYNC_A, 1'b1);
    send_link_byte(SYNC_A, 1'b1);
    send_link_byte(SYNC_B, 1'b1);
    send_frame(FRAME_BAD_ID, 8'd0, 8'd0);
    send_frame(FRAME_BAD_ID, 8'(FRAME_MAX_ID + 1), 8'd0);
    send_frame(FRAME_BAD_LEN, 8'(FRAME_MAX_ID), 8'(FRAME_MAX_LEN + 1));
    send_frame(FRAME_GOOD, 8'(FRAME_MAX_ID), 8'd1);
    send_frame(FRAME_GOOD, 8'd2, 8'd0);

    // back-to-back frames against a long payload stall
    gaps_off = 1'b1;
    hold_request = 1'b1;
    repeat (5) send_frame(FRAME_GOOD, 8'd1, 8'd10);
    gaps_off = 1'b0;

    frame_items = 0;
    for (int p = 0; p < 4; p++) begin
      set_id_mask(phase_mask[p]);
      while (frame_items < (p + 1) * PHASE_ITEMS) send_random_frame();
    end
    in_valid <= 1'b0;

    wait (beats_pending == 0);
    repeat (DRAIN_CYCLES * 2) @(posedge clk);
    if (mismatch_count == 0 && beats_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/xfpr_pkg.sv
hw/rtl/xfpr_ram.sv
hw/rtl/xfpr_parser.sv
hw/rtl/xfpr_desc_fifo.sv
hw/rtl/xfpr_drain.sv
hw/rtl/xor_framed_packet_receiver.sv
tb/xfpr_checker.sv
tb/tb.sv
